// ----- src/cpd_pkg.sv -----
// Shared types and constants for the command packet deframer.
`default_nettype none

package cpd_pkg;

  localparam int PACKET_BYTES = 10;
  localparam int WIN_DEPTH    = PACKET_BYTES - 1;
  localparam int FILL_W       = $clog2(PACKET_BYTES);
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HEAD_A  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_B  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_ID = 2'd2;

  localparam logic [7:0] HOST_ID_RST = 8'd105;

  typedef enum logic [1:0] {
    KIND_CMD = 2'd0,
    KIND_ACK = 2'd1,
    KIND_NAK = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] head_a;
    logic [7:0] head_b;
    logic [7:0] host_id;
  } cfg_t;

  typedef struct packed {
    logic        emit;
    kind_e       kind;
    logic [7:0]  dest;
    logic [7:0]  code;
    logic [31:0] data;
    logic [7:0]  src;
  } res_t;

endpackage

`default_nettype wire

// ----- src/command_packet_deframer.sv -----
// Top level of the command packet deframer.
//
// Usage: receive bytes enter on the input channel (in_vld_i, rx_byte_i,
// in_stall_o), one beat per byte. A sliding window of the last ten bytes
// is checked as a command packet; each good packet leaves as one beat on
// the output channel (out_vld_o, out_stall_i and the decoded fields).
// A byte is registered on acceptance and checked from the input register; a
// good packet is presented from the result register. Throughput is one byte
// per cycle while in_stall_o is low, set by the single window check stage
// between the input and result registers. When the receiver stalls, the
// result register holds its beat; bytes that complete no packet keep flowing,
// and the input stalls only when a byte would complete a packet while the
// result register is still occupied. Reset empties the window and both
// registers; head bytes reset to zero and the host id to 105. Configuration
// writes go through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must make
// them only while the block is idle, as the block has no check for it.
`default_nettype none

module command_packet_deframer
  import cpd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]           cfg_wdata_i,
  input  wire logic                 in_vld_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           rx_byte_i,
  output logic                      out_vld_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                packet_kind_o,
  output logic [7:0]                dest_id_o,
  output logic [7:0]                command_code_o,
  output logic [31:0]               data_word_o,
  output logic [7:0]                source_id_o
);

  cfg_t       cfg;
  res_t       res;
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       out_vld_q, out_vld_d;
  res_t       out_q;
  logic       out_free, step, in_acc, out_load;

  cpd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cpd_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .byte_i (in_byte_q),
    .step_i (step),
    .res_o  (res)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && (!res.emit || out_free);
  assign in_stall_o = in_vld_q && !step;
  assign in_acc     = in_vld_i && !in_stall_o;
  assign out_load   = step && res.emit;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  assign out_vld_d = out_load || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= rx_byte_i;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_vld_o      = out_vld_q;
  assign packet_kind_o  = 2'(out_q.kind);
  assign dest_id_o      = out_q.dest;
  assign command_code_o = out_q.code;
  assign data_word_o    = out_q.data;
  assign source_id_o    = out_q.src;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |-> !out_load)
    else $error("held result overwritten");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (res.emit && out_vld_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_vld_o)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- src/cpd_cfg.sv -----
// Configuration registers: head bytes and host id.
`default_nettype none

module cpd_cfg
  import cpd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]           cfg_wdata_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEAD_A:  cfg_d.head_a  = cfg_wdata_i;
        REG_HEAD_B:  cfg_d.head_b  = cfg_wdata_i;
        REG_HOST_ID: cfg_d.host_id = cfg_wdata_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_a  <= '0;
      cfg_q.head_b  <= '0;
      cfg_q.host_id <= HOST_ID_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- src/cpd_window.sv -----
// Sliding byte window with packet check and window update.
`default_nettype none

module cpd_window
  import cpd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       step_i,
  output res_t            res_o
);

  logic [7:0]        win_q [WIN_DEPTH];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              full;
  logic [7:0]        sum;
  logic              dest_ok, hdr_cmd, hdr_rep, pkt_ok;

  assign full = (fill_q == FILL_W'(WIN_DEPTH));

  // full window is win_q[0..8] plus the incoming byte as checksum
  always_comb begin
    sum = '0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      sum = sum + win_q[i];
    end
  end

  assign dest_ok = (win_q[2] == 8'd0) || (win_q[2] == cfg_i.host_id);
  assign hdr_cmd = (win_q[0] == cfg_i.head_a) && (win_q[1] == cfg_i.head_b);
  assign hdr_rep = (win_q[0] != cfg_i.head_a) && (win_q[0] == cfg_i.head_b)
                && (win_q[1] == cfg_i.head_a);
  assign pkt_ok  = full && dest_ok && (hdr_cmd || hdr_rep) && (sum == byte_i);

  always_comb begin
    res_o.emit = pkt_ok;
    if (hdr_cmd) begin
      res_o.kind = KIND_CMD;
    end else if (win_q[3] == 8'd0) begin
      res_o.kind = KIND_NAK;
    end else begin
      res_o.kind = KIND_ACK;
    end
    res_o.dest = win_q[2];
    res_o.code = win_q[3];
    res_o.data = {win_q[7], win_q[6], win_q[5], win_q[4]};
    res_o.src  = win_q[8];
  end

  always_comb begin
    fill_d = fill_q;
    if (step_i) begin
      if (!full) begin
        fill_d = fill_q + FILL_W'(1);
      end else if (pkt_ok) begin
        fill_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // partial window: write byte at fill position; bad full window: drop oldest beat, append new one
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      if (!full) begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
          if (fill_q == FILL_W'(i)) begin
            win_q[i] <= byte_i;
          end
        end
      end else if (!pkt_ok) begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[WIN_DEPTH-1] <= byte_i;
      end
    end
  end

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WIN_DEPTH))
    else $error("window fill out of range");

  a_emit_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.emit |-> full)
    else $error("packet reported from a partial window");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.emit) |=> (fill_q == '0))
    else $error("window not cleared after packet");

  a_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !full) |=> (fill_q == $past(fill_q) + FILL_W'(1)))
    else $error("window fill did not advance");

endmodule

`default_nettype wire
